@@ src/nsc_pkg.sv @@
// Shared types, codes and constants for the normalized stream compare block.
// No dependencies; the other files that use it refer to it by scoped names.
package nsc_pkg;

  localparam int SKEW_DEPTH_DEFAULT = 256;

  // Beat kind on the slave side (tuser)
  typedef enum logic [1:0] {
    ACT_BYTE_A = 2'd0,
    ACT_BYTE_B = 2'd1,
    ACT_END_A  = 2'd2,
    ACT_END_B  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    VERDICT_EQUAL    = 2'd0,
    VERDICT_DIFFER   = 2'd1,
    VERDICT_OVERFLOW = 2'd2
  } verdict_t;

  localparam logic [1:0] CFG_IGNORE_CASE  = 2'd0;
  localparam logic [1:0] CFG_IGNORE_SPACE = 2'd1;
  localparam logic [1:0] CFG_BYTE_LIMIT   = 2'd2;

  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef struct packed {
    logic        ignore_case;
    logic        ignore_space;
    logic [31:0] byte_limit;
  } cfg_t;

  typedef struct packed {
    logic       keep;
    logic [7:0] value;
  } norm_t;

  typedef struct packed {
    logic     valid;
    verdict_t code;
  } verdict_beat_t;

endpackage

@@ src/nsc_norm.sv @@
// Byte normalizer: drops blanks and folds upper case per configuration.
// Depends on nsc_pkg.
module nsc_norm (
  input  logic [7:0]    raw_byte,
  input  nsc_pkg::cfg_t cfg,
  output nsc_pkg::norm_t norm
);

  logic blank;
  logic upper;

  always_comb begin
    blank = (raw_byte == nsc_pkg::CHAR_SPACE) || (raw_byte == nsc_pkg::CHAR_TAB) ||
            (raw_byte == nsc_pkg::CHAR_CR) || (raw_byte == nsc_pkg::CHAR_LF);
    upper = (raw_byte >= nsc_pkg::CHAR_UPPER_A) && (raw_byte <= nsc_pkg::CHAR_UPPER_Z);
    norm.keep  = !(cfg.ignore_space && blank);
    norm.value = (cfg.ignore_case && upper) ? raw_byte + nsc_pkg::CASE_OFFSET : raw_byte;
  end

endmodule

@@ src/nsc_skew_mem.sv @@
// Skew store: one write port, one read port, registered read data.
// Depends on nothing but its parameter.
module nsc_skew_mem #(
  parameter int SKEW_DEPTH = 256,
  localparam int AW = $clog2(SKEW_DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [SKEW_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/nsc_ctrl.sv @@
// Compare control: stream bookkeeping, skew store push/pop, late compare
// of popped bytes and verdict generation. Depends on nsc_pkg.
module nsc_ctrl #(
  parameter int SKEW_DEPTH = nsc_pkg::SKEW_DEPTH_DEFAULT,
  localparam int AW = $clog2(SKEW_DEPTH),
  localparam int CW = $clog2(SKEW_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  nsc_pkg::action_t      action,
  input  nsc_pkg::norm_t        norm,
  input  nsc_pkg::cfg_t         cfg,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output logic [7:0]            mem_wdata,
  output logic                  mem_re,
  output logic [AW-1:0]         mem_raddr,
  input  logic [7:0]            mem_rdata,
  output nsc_pkg::verdict_beat_t verdict
);

  localparam logic [CW-1:0] FULL     = CW'(SKEW_DEPTH);
  localparam logic [AW-1:0] LAST_PTR = AW'(SKEW_DEPTH - 1);

  logic [CW-1:0] count;
  logic          leading;
  logic          differ;
  logic          overflow;
  logic          first_ended;
  logic          second_ended;
  logic [31:0]   first_taken;
  logic [31:0]   second_taken;
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic          cmp_valid;
  logic [7:0]    cmp_byte;

  logic          is_byte, is_end, side;
  logic          own_ended, other_ended;
  logic [31:0]   taken;
  logic          exact, over_limit, take, mismatch, differ_eff, active, to_lead;
  logic          set_differ, set_overflow, push, pop, end_new, finish;

  always_comb begin
    is_byte     = accept && !action[1];
    is_end      = accept && action[1];
    side        = action[0];
    own_ended   = side ? second_ended : first_ended;
    other_ended = side ? first_ended : second_ended;
    taken       = side ? second_taken : first_taken;
    exact       = !cfg.ignore_case && !cfg.ignore_space;
    over_limit  = exact && (cfg.byte_limit != 32'd0) && (taken >= cfg.byte_limit);
    take        = is_byte && !own_ended && norm.keep && !over_limit;
    // result of the pop issued on the previous beat
    mismatch    = cmp_valid && (mem_rdata != cmp_byte);
    differ_eff  = differ || mismatch;
    active      = take && !differ_eff && !overflow;
    to_lead     = (count == '0) || (leading == side);
    set_differ  = active && to_lead && other_ended;
    set_overflow = active && to_lead && !other_ended && (count == FULL);
    push        = active && to_lead && !other_ended && (count != FULL);
    pop         = active && !to_lead;
    end_new     = is_end && !own_ended;
    finish      = end_new && other_ended;

    verdict.valid = finish;
    if (overflow) begin
      verdict.code = nsc_pkg::VERDICT_OVERFLOW;
    end else if (differ_eff || (count != '0)) begin
      verdict.code = nsc_pkg::VERDICT_DIFFER;
    end else begin
      verdict.code = nsc_pkg::VERDICT_EQUAL;
    end

    mem_we    = push;
    mem_waddr = wr_ptr;
    mem_wdata = norm.value;
    mem_re    = pop;
    mem_raddr = rd_ptr;
  end

  always_ff @(posedge clk) begin
    if (rst || finish) begin
      count        <= '0;
      leading      <= 1'b0;
      differ       <= 1'b0;
      overflow     <= 1'b0;
      first_ended  <= 1'b0;
      second_ended <= 1'b0;
      first_taken  <= '0;
      second_taken <= '0;
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      cmp_valid    <= 1'b0;
    end else begin
      differ    <= differ_eff || set_differ;
      overflow  <= overflow || set_overflow;
      cmp_valid <= pop;
      if (take && (taken != 32'hFFFF_FFFF)) begin
        if (side) begin
          second_taken <= second_taken + 32'd1;
        end else begin
          first_taken <= first_taken + 32'd1;
        end
      end
      if (push) begin
        count   <= count + CW'(1);
        leading <= side;
        wr_ptr  <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end else if (pop) begin
        count  <= count - CW'(1);
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
      if (end_new) begin
        if (side) begin
          second_ended <= 1'b1;
        end else begin
          first_ended <= 1'b1;
        end
      end
    end
  end

  // hold the popping byte until its stored partner is read
  always_ff @(posedge clk) begin
    if (pop) begin
      cmp_byte <= norm.value;
    end
  end

endmodule

@@ src/normalized_stream_compare_top.sv @@
// Top level of the normalized stream compare block: config registers,
// normalizer, compare control, skew store and a two-deep verdict buffer.
// Depends on nsc_pkg, nsc_norm, nsc_skew_mem, nsc_ctrl.
//
//   channel  | signals                          | payload
//   ---------+----------------------------------+------------------------------
//   slave    | s_tvalid s_tready s_tdata s_tuser| data_byte; action
//   master   | m_tvalid m_tready m_tdata        | verdict
//   config   | cfg_we cfg_index cfg_data        | ignore_case/ignore_space/limit
//
// One beat per cycle, sustained, while s_tready is high. A popped byte is compared in the
// cycle after its pop against the skew store read data; that result feeds the next beat directly.
// The verdict is registered into the output register, or into the skid entry while the master side stalls.
// s_tready drops only while two verdicts wait unclaimed on the master side.
// rst is synchronous; it clears all compare state and the config registers.
module normalized_stream_compare_top #(
  parameter int SKEW_DEPTH = nsc_pkg::SKEW_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_tuser,   // [1:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [1:0] verdict, [7:2] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = $clog2(SKEW_DEPTH);

  nsc_pkg::cfg_t          cfg;
  nsc_pkg::norm_t         norm;
  nsc_pkg::verdict_beat_t verdict;
  logic                   accept;
  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_waddr, mem_raddr;
  logic [7:0]             mem_wdata, mem_rdata;

  logic                   out_valid, skid_valid;
  nsc_pkg::verdict_t      out_code, skid_code;
  logic                   out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nsc_pkg::CFG_IGNORE_CASE:  cfg.ignore_case  <= cfg_data[0];
        nsc_pkg::CFG_IGNORE_SPACE: cfg.ignore_space <= cfg_data[0];
        nsc_pkg::CFG_BYTE_LIMIT:   cfg.byte_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;

  nsc_norm u_norm (
    .raw_byte (s_tdata),
    .cfg      (cfg),
    .norm     (norm)
  );

  nsc_ctrl #(.SKEW_DEPTH(SKEW_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .action    (nsc_pkg::action_t'(s_tuser)),
    .norm      (norm),
    .cfg       (cfg),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .verdict   (verdict)
  );

  nsc_skew_mem #(.SKEW_DEPTH(SKEW_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register with a skid entry behind it
  assign out_free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || verdict.valid;
      skid_valid <= skid_valid && verdict.valid;
    end else if (verdict.valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_code <= skid_valid ? skid_code : verdict.code;
      if (verdict.valid) begin
        skid_code <= verdict.code;
      end
    end else if (verdict.valid) begin
      skid_code <= verdict.code;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_code};

endmodule

@@ src/nsc_checker.sv @@
// Port-level checks for normalized_stream_compare_top, attached by bind.
// Depends on nsc_pkg.
module nsc_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [1:0] s_tuser,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // verdict is a defined code, upper bits zero
  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:2] == 6'd0) && (m_tdata[1:0] <= nsc_pkg::VERDICT_OVERFLOW))
    else $error("undefined verdict code");

  // a verdict only follows an accepted end-mark beat
  a_verdict_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tuser[1]))
    else $error("verdict without an end-mark beat");

  // input stalls only while a verdict is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no verdict pending");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled verdict beat changed");

endmodule

bind normalized_stream_compare_top nsc_checker u_nsc_checker (.*);

@@ dv/tb.sv @@
// Self-checking testbench for normalized_stream_compare_top: directed and random
// interleaved byte streams, checked against an in-bench verdict predictor.
// Depends on nsc_pkg and the RTL under src/.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SKEW_DEPTH   = nsc_pkg::SKEW_DEPTH_DEFAULT;
  localparam int SETTLE       = 4;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_BEATS = 480;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  // predictor copy of the registers and the compare state
  bit                  cfg_fold;
  bit                  cfg_blank;
  logic [31:0]         cfg_limit;
  logic [7:0]          skew_fifo[$];
  bit                  skew_lead;
  bit                  differ_seen;
  bit                  overflow_seen;
  bit                  a_ended;
  bit                  b_ended;
  logic [31:0]         a_taken;
  logic [31:0]         b_taken;
  nsc_pkg::verdict_t   pending_verdicts[$];

  int error_count;
  int beats_sent;
  int stall_cycles;
  int src_gap_pct;
  int sink_stall_pct;
  bit hold_request;
  bit hold_active;

  always #5ns clk = ~clk;

  normalized_stream_compare_top u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic bit is_blank(logic [7:0] c);
    return c == nsc_pkg::CHAR_SPACE || c == nsc_pkg::CHAR_TAB ||
           c == nsc_pkg::CHAR_CR || c == nsc_pkg::CHAR_LF;
  endfunction

  function automatic void clear_compare();
    skew_fifo.delete();
    skew_lead = 1'b0;
    differ_seen = 1'b0;
    overflow_seen = 1'b0;
    a_ended = 1'b0;
    b_ended = 1'b0;
    a_taken = '0;
    b_taken = '0;
  endfunction

  function automatic void absorb_byte(bit strm, logic [7:0] raw);
    logic [7:0]  c;
    logic [31:0] cnt;
    bit          own_done;
    bit          other_done;
    bit          exact;
    c = raw;
    own_done = strm ? b_ended : a_ended;
    other_done = strm ? a_ended : b_ended;
    cnt = strm ? b_taken : a_taken;
    exact = !cfg_fold && !cfg_blank;
    if (own_done) return;
    if (cfg_blank && is_blank(c)) return;
    if (cfg_fold && c >= nsc_pkg::CHAR_UPPER_A && c <= nsc_pkg::CHAR_UPPER_Z)
      c = c + nsc_pkg::CASE_OFFSET;
    if (exact && cfg_limit != 0 && cnt >= cfg_limit) return;
    if (cnt != '1) cnt = cnt + 1;
    if (strm) b_taken = cnt;
    else a_taken = cnt;
    // once a flag is up, the verdict is settled
    if (differ_seen || overflow_seen) return;
    if (skew_fifo.size() == 0 || skew_lead == strm) begin
      if (other_done) begin
        differ_seen = 1'b1;
        return;
      end
      if (skew_fifo.size() >= SKEW_DEPTH) begin
        overflow_seen = 1'b1;
        return;
      end
      skew_fifo.push_back(c);
      skew_lead = strm;
    end else begin
      if (skew_fifo.pop_front() != c) differ_seen = 1'b1;
    end
  endfunction

  function automatic void compare_beat(nsc_pkg::action_t act, logic [7:0] c);
    case (act)
      nsc_pkg::ACT_BYTE_A: begin
        absorb_byte(1'b0, c);
        return;
      end
      nsc_pkg::ACT_BYTE_B: begin
        absorb_byte(1'b1, c);
        return;
      end
      nsc_pkg::ACT_END_A: begin
        if (a_ended) return;
        a_ended = 1'b1;
      end
      default: begin
        if (b_ended) return;
        b_ended = 1'b1;
      end
    endcase
    if (!(a_ended && b_ended)) return;
    if (overflow_seen) pending_verdicts.push_back(nsc_pkg::VERDICT_OVERFLOW);
    else if (differ_seen || skew_fifo.size() != 0)
      pending_verdicts.push_back(nsc_pkg::VERDICT_DIFFER);
    else pending_verdicts.push_back(nsc_pkg::VERDICT_EQUAL);
    clear_compare();
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 3))
      0: return nsc_pkg::CHAR_SPACE;
      1: return nsc_pkg::CHAR_TAB;
      2: return nsc_pkg::CHAR_CR;
      default: return nsc_pkg::CHAR_LF;
    endcase
  endfunction

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'($urandom);
      3, 4: return 8'($urandom_range(8'h41, 8'h5A));
      5, 6: return 8'($urandom_range(8'h61, 8'h7A));
      7: return pick_blank();
      8: begin
        case ($urandom_range(0, 7))
          0: return 8'h40;
          1: return 8'h5B;
          2: return 8'h60;
          3: return 8'h7B;
          4: return 8'h00;
          5: return 8'hFF;
          6: return 8'h0B;
          default: return 8'h0C;
        endcase
      end
      default: return 8'($urandom_range(8'h30, 8'h39));
    endcase
  endfunction

  task automatic send_beat(nsc_pkg::action_t act, logic [7:0] b);
    if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
      s_tvalid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    compare_beat(act, b);
    beats_sent++;
  endtask

  task automatic send_text(nsc_pkg::action_t act, string s);
    int i;
    for (i = 0; i < s.len(); i++) send_beat(act, s[i]);
  endtask

  // drop the offered beat, then wait for every expected verdict
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // one-bit registers get random upper bits; only bit 0 counts
  task automatic write_config(bit fold, bit blank, logic [31:0] limit);
    wait_drain();
    s_tvalid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= nsc_pkg::CFG_IGNORE_CASE;
    cfg_data <= ($urandom() & 32'hFFFF_FFFE) | 32'(fold);
    @(posedge clk);
    cfg_index <= nsc_pkg::CFG_IGNORE_SPACE;
    cfg_data <= ($urandom() & 32'hFFFF_FFFE) | 32'(blank);
    @(posedge clk);
    cfg_index <= nsc_pkg::CFG_BYTE_LIMIT;
    cfg_data <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_fold = fold;
    cfg_blank = blank;
    cfg_limit = limit;
  endtask

  task automatic test_exact_mode();
    write_config(1'b0, 1'b0, 32'd0);
    send_beat(nsc_pkg::ACT_BYTE_A, "a");
    send_beat(nsc_pkg::ACT_BYTE_B, "a");
    send_beat(nsc_pkg::ACT_BYTE_A, "b");
    send_beat(nsc_pkg::ACT_BYTE_B, "b");
    send_beat(nsc_pkg::ACT_END_A, 8'hFF);
    send_beat(nsc_pkg::ACT_END_B, 8'h00);
    send_beat(nsc_pkg::ACT_BYTE_A, 8'h00);
    send_beat(nsc_pkg::ACT_BYTE_A, 8'hFF);
    send_beat(nsc_pkg::ACT_BYTE_B, 8'h00);
    send_beat(nsc_pkg::ACT_BYTE_B, 8'hFE);
    send_beat(nsc_pkg::ACT_END_B, 8'h55);
    send_beat(nsc_pkg::ACT_END_A, 8'hAA);
    // repeated end mark and a byte after the stream's own end
    send_text(nsc_pkg::ACT_BYTE_A, "xy");
    send_beat(nsc_pkg::ACT_END_A, 8'h00);
    send_beat(nsc_pkg::ACT_END_A, 8'h00);
    send_beat(nsc_pkg::ACT_BYTE_A, "z");
    send_text(nsc_pkg::ACT_BYTE_B, "xy");
    send_beat(nsc_pkg::ACT_END_B, 8'h00);
    // second stream runs on after the first ended with nothing waiting
    send_beat(nsc_pkg::ACT_BYTE_A, "q");
    send_beat(nsc_pkg::ACT_END_A, 8'h00);
    send_text(nsc_pkg::ACT_BYTE_B, "qr");
    send_beat(nsc_pkg::ACT_END_B, 8'h00);
    // bytes left waiting at the end
    send_text(nsc_pkg::ACT_BYTE_A, "abc");
    send_text(nsc_pkg::ACT_BYTE_B, "ab");
    send_beat(nsc_pkg::ACT_END_B, 8'h00);
    send_beat(nsc_pkg::ACT_END_A, 8'h00);
    send_beat(nsc_pkg::ACT_END_B, 8'h00);
    send_beat(nsc_pkg::ACT_END_A, 8'h00);
  endtask

  task automatic test_case_and_blank();
    write_config(1'b1, 1'b0, 32'd0);
    send_text(nsc_pkg::ACT_BYTE_A, "AZ@[aB");
    send_text(nsc_pkg::ACT_BYTE_B, "az@[Ab");
    send_beat(nsc_pkg::ACT_END_A, 8'h00);
    send_beat(nsc_pkg::ACT_END_B, 8'h00);
    send_text(nsc_pkg::ACT_BYTE_B, "@[");
    send_text(nsc_pkg::ACT_BYTE_A, "`{");
    send_beat(nsc_pkg::ACT_END_B, 8'h00);
    send_beat(nsc_pkg::ACT_END_A, 8'h00);
    // limit is ignored outside exact mode
    write_config(1'b0, 1'b1, 32'd1);
    send_text(nsc_pkg::ACT_BYTE_A, " a\tb\r\n");
    send_text(nsc_pkg::ACT_BYTE_B, "ab ");
    send_beat(nsc_pkg::ACT_END_A, 8'h00);
    send_beat(nsc_pkg::ACT_END_B, 8'h00);
    send_text(nsc_pkg::ACT_BYTE_A, "a");
    send_text(nsc_pkg::ACT_BYTE_B, "\nA");
    send_beat(nsc_pkg::ACT_END_A, 8'h00);
    send_beat(nsc_pkg::ACT_END_B, 8'h00);
    write_config(1'b1, 1'b1, 32'd0);
    send_text(nsc_pkg::ACT_BYTE_A, "A B");
    send_text(nsc_pkg::ACT_BYTE_B, "a\nb\t");
    send_beat(nsc_pkg::ACT_END_B, 8'h00);
    send_beat(nsc_pkg::ACT_END_A, 8'h00);
  endtask

  task automatic test_byte_limit();
    write_config(1'b0, 1'b0, 32'd2);
    send_text(nsc_pkg::ACT_BYTE_A, "abX");
    send_text(nsc_pkg::ACT_BYTE_B, "abY");
    send_beat(nsc_pkg::ACT_END_A, 8'h00);
    send_beat(nsc_pkg::ACT_END_B, 8'h00);
    write_config(1'b0, 1'b0, 32'd1);
    send_text(nsc_pkg::ACT_BYTE_A, "a");
    send_text(nsc_pkg::ACT_BYTE_B, "ab");
    send_beat(nsc_pkg::ACT_END_B, 8'h00);
    send_beat(nsc_pkg::ACT_END_A, 8'h00);
    write_config(1'b0, 1'b0, 32'hFFFF_FFFF);
    send_text(nsc_pkg::ACT_BYTE_A, "ab");
    send_text(nsc_pkg::ACT_BYTE_B, "ac");
    send_beat(nsc_pkg::ACT_END_A, 8'h00);
    send_beat(nsc_pkg::ACT_END_B, 8'h00);
  endtask

  task automatic test_skew_overflow();
    logic [7:0] txt[$];
    int i;
    write_config(1'b0, 1'b0, 32'd0);
    // store exactly full, then drained by the other stream
    for (i = 0; i < SKEW_DEPTH; i++) txt.push_back(8'($urandom));
    foreach (txt[k]) send_beat(nsc_pkg::ACT_BYTE_B, txt[k]);
    foreach (txt[k]) send_beat(nsc_pkg::ACT_BYTE_A, txt[k]);
    send_beat(nsc_pkg::ACT_END_A, 8'h00);
    send_beat(nsc_pkg::ACT_END_B, 8'h00);
    // one byte past full
    for (i = 0; i <= SKEW_DEPTH; i++) send_beat(nsc_pkg::ACT_BYTE_A, 8'($urandom));
    send_text(nsc_pkg::ACT_BYTE_B, "ab");
    send_beat(nsc_pkg::ACT_END_B, 8'h00);
    send_beat(nsc_pkg::ACT_END_A, 8'h00);
    // an earlier mismatch wins over a later overflow
    send_beat(nsc_pkg::ACT_BYTE_A, "x");
    send_beat(nsc_pkg::ACT_BYTE_B, "y");
    for (i = 0; i < SKEW_DEPTH + 8; i++) send_beat(nsc_pkg::ACT_BYTE_A, 8'($urandom));
    send_beat(nsc_pkg::ACT_END_A, 8'h00);
    send_beat(nsc_pkg::ACT_END_B, 8'h00);
  endtask

  task automatic test_output_backpressure();
    int i;
    write_config(1'b0, 1'b0, 32'd0);
    src_gap_pct = 0;
    sink_stall_pct = 0;
    hold_request = 1'b1;
    wait (hold_active);
    for (i = 0; i < 24; i++) begin
      send_beat(nsc_pkg::ACT_BYTE_A, "k");
      send_beat(nsc_pkg::ACT_BYTE_B, 8'(i));
      send_beat(nsc_pkg::ACT_END_B, 8'($urandom));
      send_beat(nsc_pkg::ACT_END_A, 8'($urandom));
    end
    wait_drain();
    // sender waits for each verdict before the next pair
    for (i = 0; i < 4; i++) begin
      send_beat(nsc_pkg::ACT_END_A, 8'($urandom));
      send_beat(nsc_pkg::ACT_END_B, 8'($urandom));
      wait_drain();
    end
  endtask

  task automatic run_random_pair();
    logic [7:0]       a_txt[$];
    logic [7:0]       b_txt[$];
    logic [7:0]       c;
    int               n;
    int               r;
    int               mode;
    int               ia;
    int               ib;
    bit               side;
    bit               ea;
    bit               eb;
    nsc_pkg::action_t act;
    r = $urandom_range(0, 99);
    if (r < 4) n = $urandom_range(250, 300);
    else if (r < 10) n = $urandom_range(20, 80);
    else n = $urandom_range(0, 12);
    repeat (n) a_txt.push_back(pick_char());
    case ($urandom_range(0, 4))
      0: b_txt = a_txt;
      1: begin
        foreach (a_txt[i]) begin
          if (cfg_blank && $urandom_range(0, 3) == 0) b_txt.push_back(pick_blank());
          c = a_txt[i];
          if (cfg_fold && $urandom_range(0, 1)) begin
            if (c >= 8'h41 && c <= 8'h5A) c = c + nsc_pkg::CASE_OFFSET;
            else if (c >= 8'h61 && c <= 8'h7A) c = c - nsc_pkg::CASE_OFFSET;
          end
          b_txt.push_back(c);
        end
      end
      2: begin
        b_txt = a_txt;
        if (b_txt.size() != 0) b_txt[$urandom_range(0, b_txt.size() - 1)] = pick_char();
      end
      3: begin
        b_txt = a_txt;
        if (b_txt.size() != 0 && $urandom_range(0, 1)) void'(b_txt.pop_back());
        else b_txt.push_back(pick_char());
      end
      default: repeat ($urandom_range(0, 12)) b_txt.push_back(pick_char());
    endcase
    mode = $urandom_range(0, 3);
    ia = 0;
    ib = 0;
    ea = 1'b0;
    eb = 1'b0;
    while (!(ea && eb)) begin
      if ($urandom_range(0, 99) < 2) begin
        // noise: any beat at all, possibly an early or repeated end mark
        act = nsc_pkg::action_t'($urandom_range(0, 3));
        send_beat(act, 8'($urandom));
        if (act == nsc_pkg::ACT_END_A) ea = 1'b1;
        if (act == nsc_pkg::ACT_END_B) eb = 1'b1;
      end else begin
        if (mode == 0) side = ea;
        else if (mode == 1) side = !eb;
        else if (ea) side = 1'b1;
        else if (eb) side = 1'b0;
        else side = 1'($urandom_range(0, 1));
        if (!side) begin
          if (ia < a_txt.size()) begin
            send_beat(nsc_pkg::ACT_BYTE_A, a_txt[ia]);
            ia++;
          end else begin
            send_beat(nsc_pkg::ACT_END_A, 8'($urandom));
            ea = 1'b1;
          end
        end else begin
          if (ib < b_txt.size()) begin
            send_beat(nsc_pkg::ACT_BYTE_B, b_txt[ib]);
            ib++;
          end else begin
            send_beat(nsc_pkg::ACT_END_B, 8'($urandom));
            eb = 1'b1;
          end
        end
      end
    end
  endtask

  task automatic test_random_streams();
    int seg;
    int stop_at;
    for (seg = 0; seg < 8; seg++) begin
      case (seg)
        0: write_config(1'b0, 1'b0, 32'd0);
        1: write_config(1'b1, 1'b0, 32'd0);
        2: write_config(1'b0, 1'b1, 32'd0);
        3: write_config(1'b1, 1'b1, $urandom());
        4: write_config(1'b0, 1'b0, $urandom_range(1, 12));
        5: write_config(1'b0, 1'b0, 32'hFFFF_FFFF);
        6: write_config(1'b0, 1'b0, 32'd1);
        default: write_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 20));
      endcase
      // one stretch with no idling on either side
      src_gap_pct = (seg == 5) ? 0 : $urandom_range(5, 40);
      sink_stall_pct = (seg == 5) ? 0 : $urandom_range(5, 40);
      stop_at = beats_sent + RANDOM_BEATS / 8;
      while (beats_sent < stop_at) run_random_pair();
    end
  endtask

  // result side: random stalls, plus the long hold-off on request
  initial begin
    m_tready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_active = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
      end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
        m_tready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected verdict beat: verdict %0d", m_tdata[1:0]);
        error_count++;
      end else begin
        if (m_tdata[1:0] !== pending_verdicts[0]) begin
          $error("verdict mismatch: expected %0d, actual %0d",
                 pending_verdicts[0], m_tdata[1:0]);
          error_count++;
        end
        if (m_tdata[7:2] !== 6'd0) begin
          $error("tdata padding mismatch: expected 0, actual %0d", m_tdata[7:2]);
          error_count++;
        end
        void'(pending_verdicts.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $error("no beat moved for %0d cycles", STALL_LIMIT);
      $display("normalized_stream_compare_top regression: fail");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= 8'd0;
    s_tuser <= nsc_pkg::ACT_BYTE_A;
    cfg_we <= 1'b0;
    cfg_index <= nsc_pkg::CFG_IGNORE_CASE;
    cfg_data <= 32'd0;
    cfg_fold = 1'b0;
    cfg_blank = 1'b0;
    cfg_limit = '0;
    clear_compare();
    src_gap_pct = 25;
    sink_stall_pct = 25;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_exact_mode();
    test_case_and_blank();
    test_byte_limit();
    test_skew_overflow();
    test_output_backpressure();
    test_random_streams();
    wait_drain();
    repeat (8) @(posedge clk);
    if (error_count == 0 && pending_verdicts.size() == 0) begin
      $display("normalized_stream_compare_top regression: pass");
    end else begin
      if (pending_verdicts.size() != 0)
        $error("%0d expected verdicts never arrived", pending_verdicts.size());
      $display("normalized_stream_compare_top regression: fail");
    end
    $finish;
  end

endmodule
